// File: rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding window max/min block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int CFG_BITS = 7;

    typedef struct packed {
        logic start;
        logic clear;
    } dq_cmd_t;

endpackage

// File: rtl/swmm_ram.sv
// ----------------------------------------------------------------------------
// swmm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/swmm_deque.sv
// ----------------------------------------------------------------------------
// swmm_deque
// Monotonic deque held in a ring buffer RAM: front expiry, back pops, push.
// ----------------------------------------------------------------------------
module swmm_deque
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter bit KEEP_MAX    = 1'b1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dq_cmd_t                             cmd,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [$clog2(WINDOW_MAX)+1-1:0]     pos,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]     len,
    output logic                                busy,
    output logic signed [SAMPLE_BITS-1:0]       front
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = CW + 1;
    localparam int ST = $clog2(WINDOW_MAX) + 1;
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int EW = SAMPLE_BITS + ST;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPIRE,
        S_BACK,
        S_PUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [ST-1:0]           pos_reg, pos_next;
    logic [LW-1:0]           len_reg, len_next;
    logic signed [SAMPLE_BITS-1:0] front_reg, front_next;

    logic [AW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;

    logic signed [SAMPLE_BITS-1:0] rd_value;
    logic [ST-1:0]           rd_stamp;
    logic [ST-1:0]           age;
    logic                    expired;
    logic                    dominated;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offs);
        if (sum >= SW'(WINDOW_MAX)) begin
            sum = sum - SW'(WINDOW_MAX);
        end
        return sum[AW-1:0];
    endfunction

    swmm_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_value = $signed(rd_data[EW-1:ST]);
    assign rd_stamp = rd_data[ST-1:0];
    assign age      = pos_reg - rd_stamp;
    assign expired  = (age >= ST'(len_reg));
    assign dominated = KEEP_MAX ? (rd_value < sample_reg) : (rd_value > sample_reg);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        sample_next = sample_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        front_next  = front_reg;
        rd_addr     = head_reg;
        wr_en       = 1'b0;
        wr_addr     = ring_add(head_reg, count_reg);
        wr_data     = {sample_reg, pos_reg};

        case (state_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    sample_next = sample;
                    pos_next    = pos;
                    len_next    = len;
                    if (cmd.clear) begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    rd_addr    = head_next;
                    state_next = (count_next == '0) ? S_PUSH : S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (expired) begin
                    head_next  = ring_add(head_reg, CW'(1));
                    count_next = count_reg - CW'(1);
                    rd_addr    = head_next;
                    if (count_reg == CW'(1)) begin
                        state_next = S_PUSH;
                    end
                end else begin
                    front_next = rd_value;
                    rd_addr    = ring_add(head_reg, count_reg - CW'(1));
                    state_next = S_BACK;
                end
            end
            S_BACK: begin
                if (dominated) begin
                    count_next = count_reg - CW'(1);
                    rd_addr    = ring_add(head_reg, count_reg - CW'(2));
                    if (count_reg == CW'(1)) begin
                        state_next = S_PUSH;
                    end
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                if (count_reg == '0) begin
                    front_next = sample_reg;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        sample_reg <= sample_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
        front_reg  <= front_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign front = front_reg;

endmodule

// File: rtl/sliding_window_max_min.sv
// ----------------------------------------------------------------------------
// sliding_window_max_min
// Running maximum, minimum and range over the last window_len samples.
// ----------------------------------------------------------------------------
// Input channel s_*: one signed sample per transfer, with a flag that restarts
// the sequence (both deques emptied, position back to zero) before the sample.
// Result channel m_*: window maximum, minimum and their unsigned difference,
// exactly one result per input transfer, in order.
// Configuration channel cfg_*: window length, always ready; zero acts as one,
// values above WINDOW_MAX act as WINDOW_MAX. Write only while idle.
// Each deque lives in a one-read, one-write RAM; entries are checked one per
// cycle on its read port. The result is registered once both deques have
// dropped expired entries from the front, popped dominated entries from the
// back and pushed the sample; an empty deque goes straight to the push.
// One item is worked on at a time; the next is taken once the result is in
// the output register. A stalled receiver holds one result while the
// following item is processed, then back-pressures the input.
// Reset empties both deques, zeroes the position and sets the window to one.
// ----------------------------------------------------------------------------
module sliding_window_max_min
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_first_of_sequence,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_window_max,
    output logic signed [SAMPLE_BITS-1:0] m_window_min,
    output logic [SAMPLE_BITS-1:0]        m_window_range
);

    localparam int ST       = $clog2(WINDOW_MAX) + 1;
    localparam int LW       = $clog2(WINDOW_MAX + 1);
    localparam int CMP_BITS = (LW > CFG_BITS) ? LW : CFG_BITS;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t                        state_reg;
    logic [CFG_BITS-1:0]           window_len_reg;
    logic [ST-1:0]                 pos_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg, min_reg;
    logic [SAMPLE_BITS-1:0]        range_reg;

    dq_cmd_t                       cmd;
    logic [ST-1:0]                 pos_cur;
    logic [CMP_BITS-1:0]           len_wide;
    logic [LW-1:0]                 len_eff;
    logic                          max_busy, min_busy;
    logic signed [SAMPLE_BITS-1:0] max_front, min_front;
    logic                          load;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign cmd.start = s_valid && s_ready;
    assign cmd.clear = s_first_of_sequence;
    assign pos_cur   = s_first_of_sequence ? '0 : pos_reg;
    assign len_wide  = CMP_BITS'(window_len_reg);

    always_comb begin
        if (len_wide == '0) begin
            len_eff = LW'(1);
        end else if (len_wide > CMP_BITS'(WINDOW_MAX)) begin
            len_eff = LW'(WINDOW_MAX);
        end else begin
            len_eff = len_wide[LW-1:0];
        end
    end

    swmm_deque #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .KEEP_MAX    (1'b1)
    ) u_max_dq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (s_sample),
        .pos     (pos_cur),
        .len     (len_eff),
        .busy    (max_busy),
        .front   (max_front)
    );

    swmm_deque #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .KEEP_MAX    (1'b0)
    ) u_min_dq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (s_sample),
        .pos     (pos_cur),
        .len     (len_eff),
        .busy    (min_busy),
        .front   (min_front)
    );

    assign load = (state_reg == S_BUSY) && !max_busy && !min_busy
                  && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            window_len_reg <= CFG_BITS'(1);
            pos_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_len_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd.start) begin
                        pos_reg   <= pos_cur + ST'(1);
                        state_reg <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load) begin
            max_reg   <= max_front;
            min_reg   <= min_front;
            range_reg <= max_front - min_front;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_max   = max_reg;
    assign m_window_min   = min_reg;
    assign m_window_range = range_reg;

endmodule

// File: rtl/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks for sliding_window_max_min, bound to the top level.
// ----------------------------------------------------------------------------
module swmm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_window_max,
    input logic signed [SAMPLE_BITS-1:0] m_window_min,
    input logic [SAMPLE_BITS-1:0]        m_window_range
);

    logic [SAMPLE_BITS-1:0] diff;
    assign diff = m_window_max - m_window_min;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_max)
                                && $stable(m_window_min) && $stable(m_window_range))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_window_range == diff) && (m_window_max >= m_window_min))
        else $error("range inconsistent with max and min");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

endmodule

bind sliding_window_max_min swmm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swmm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_window_max   (m_window_max),
    .m_window_min   (m_window_min),
    .m_window_range (m_window_range)
);

// File: tb/sliding_window_max_min_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_max_min_tb
// Self-checking testbench for the sliding window max/min block.
// ----------------------------------------------------------------------------
// A behavioural copy of the two monotonic deques predicts maximum, minimum and
// range for every accepted sample. Each result transfer is checked against
// the oldest prediction. Directed samples cover the field extremes, equal
// samples, restarts and the saturating window lengths. Random sequences then
// cover window changes mid-sequence, position wrap and a range of content
// shapes, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module sliding_window_max_min_tb import swmm_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W       = 16;
    localparam int DEPTH          = 64;
    localparam int STAMP_W        = 8;
    localparam int MAX_DQ         = 0;
    localparam int MIN_DQ         = 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t               wmax;
        sample_t               wmin;
        logic [SAMPLE_W-1:0]   wrange;
    } window_result_t;

    typedef enum int {
        MODE_RANDOM,
        MODE_NARROW,
        MODE_RISING,
        MODE_FALLING,
        MODE_EXTREME
    } content_t;

    logic                  aclk                = 1'b0;
    logic                  aresetn             = 1'b0;
    logic                  cfg_valid           = 1'b0;
    logic                  cfg_ready;
    logic [CFG_BITS-1:0]   cfg_data            = '0;
    logic                  s_valid             = 1'b0;
    logic                  s_ready;
    sample_t               s_sample            = '0;
    logic                  s_first_of_sequence = 1'b0;
    logic                  m_valid;
    logic                  m_ready             = 1'b0;
    sample_t               m_window_max;
    sample_t               m_window_min;
    logic [SAMPLE_W-1:0]   m_window_range;

    // deque model: index MAX_DQ holds candidate maxima, MIN_DQ candidate minima
    sample_t               dq_value [2][DEPTH];
    logic [STAMP_W-1:0]    dq_stamp [2][DEPTH];
    logic [5:0]            dq_head  [2];
    logic [6:0]            dq_count [2];
    logic [STAMP_W-1:0]    position;
    logic [CFG_BITS-1:0]   window_reg;

    window_result_t        pending_results [$];
    sample_t               last_sample = '0;
    bit                    quiet = 1'b0;
    int                    errors = 0;
    int                    stall_left = 0;
    int                    stalled_cycles = 0;

    sliding_window_max_min #(
        .WINDOW_MAX  (DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sample            (s_sample),
        .s_first_of_sequence (s_first_of_sequence),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_window_max        (m_window_max),
        .m_window_min        (m_window_min),
        .m_window_range      (m_window_range)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void deque_take(int side, sample_t v, logic [6:0] len);
        logic [STAMP_W-1:0] age;
        logic [5:0]         slot_idx;
        sample_t            back;
        while (dq_count[side] != 0) begin
            age = position - dq_stamp[side][dq_head[side]];
            if (age < len) break;
            dq_head[side]  += 1;
            dq_count[side] -= 1;
        end
        while (dq_count[side] != 0) begin
            slot_idx = dq_head[side] + dq_count[side] - 1;
            back = dq_value[side][slot_idx];
            if ((side == MAX_DQ) ? (back >= v) : (back <= v)) break;
            dq_count[side] -= 1;
        end
        slot_idx = dq_head[side] + dq_count[side];
        dq_value[side][slot_idx] = v;
        dq_stamp[side][slot_idx] = position;
        dq_count[side] += 1;
    endfunction

    function automatic window_result_t predict_window(sample_t s, logic first);
        logic [6:0]     len;
        window_result_t r;
        len = window_reg;
        if (len == 0) len = 1;
        else if (len > DEPTH) len = DEPTH;
        if (first) begin
            dq_head  = '{default: '0};
            dq_count = '{default: '0};
            position = '0;
        end
        deque_take(MAX_DQ, s, len);
        deque_take(MIN_DQ, s, len);
        position += 1;
        r.wmax   = dq_value[MAX_DQ][dq_head[MAX_DQ]];
        r.wmin   = dq_value[MIN_DQ][dq_head[MIN_DQ]];
        r.wrange = r.wmax - r.wmin;
        return r;
    endfunction

    function automatic sample_t next_sample(content_t mode);
        case (mode)
            MODE_NARROW:  return sample_t'(int'($urandom_range(0, 8)) - 4);
            MODE_RISING:  return last_sample + sample_t'($urandom_range(0, 40));
            MODE_FALLING: return last_sample - sample_t'($urandom_range(0, 40));
            MODE_EXTREME: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default:      return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_sample(sample_t s, logic first);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_sample            <= s;
        s_first_of_sequence <= first;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_window(s, first));
        last_sample = s;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic set_window(logic [CFG_BITS-1:0] len);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        window_reg = len;
    endtask

    // noisy: stray restarts dropped into the sequence
    task automatic run_sequence(int n, bit restart, bit noisy);
        content_t mode;
        logic     first;
        mode = content_t'($urandom_range(0, 4));
        for (int i = 0; i < n; i++) begin
            if (i % 16 == 15) mode = content_t'($urandom_range(0, 4));
            first = (i == 0 && restart) || (noisy && $urandom_range(0, 39) == 0);
            send_sample(next_sample(mode), first);
        end
    endtask

    task automatic test_directed();
        // window still at its reset value of one
        send_sample(32767, 1'b1);
        send_sample(-32768, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        // zero acts as one
        set_window(0);
        send_sample(100, 1'b1);
        send_sample(-100, 1'b0);
        // full range, equal samples, restart mid-stream
        set_window(3);
        send_sample(-32768, 1'b1);
        send_sample(32767, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(7, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(42, 1'b1);
        // saturates at the deque depth
        set_window(127);
        send_sample(1, 1'b1);
        send_sample(-2, 1'b0);
        send_sample(3, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(32767, 1'b0);
    endtask

    task automatic test_window_lengths();
        int lens[9] = '{1, 2, 3, 63, 64, 65, 100, 0, 0};
        lens[8] = $urandom_range(4, 62);
        foreach (lens[i]) begin
            set_window(CFG_BITS'(lens[i]));
            run_sequence(40, 1'b1, 1'b0);
        end
    endtask

    task automatic test_length_change();
        set_window(8);
        run_sequence(30, 1'b1, 1'b0);
        set_window(2);
        run_sequence(20, 1'b0, 1'b0);
        set_window(64);
        run_sequence(30, 1'b0, 1'b0);
        set_window(127);
        run_sequence(20, 1'b0, 1'b0);
    endtask

    task automatic test_position_wrap();
        set_window(64);
        run_sequence(300, 1'b1, 1'b0);
        set_window(5);
        run_sequence(100, 1'b0, 1'b0);
    endtask

    task automatic test_sender_pause();
        run_sequence(20, 1'b1, 1'b0);
        drain_results();
        run_sequence(20, 1'b0, 1'b0);
    endtask

    task automatic test_random(int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 2) == 0)
                set_window(CFG_BITS'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(1, 64)));
            quiet = ($urandom_range(0, 4) == 0);
            len = $urandom_range(1, 80);
            run_sequence(len, $urandom_range(0, 9) != 0, 1'b1);
            sent += len;
        end
        quiet = 1'b0;
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        set_window(CFG_BITS'($urandom_range(1, 64)));
        run_sequence(150, 1'b1, 1'b1);
    endtask

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // result channel back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        window_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected transfer, expected none, actual max %0d min %0d",
                         $time, m_window_max, m_window_min);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("window_max", want.wmax, m_window_max);
                compare_field("window_min", want.wmin, m_window_min);
                compare_field("window_range", want.wrange, m_window_range);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        dq_head    = '{default: '0};
        dq_count   = '{default: '0};
        position   = '0;
        window_reg = 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_window_lengths();
        test_length_change();
        test_position_wrap();
        test_sender_pause();
        test_random(380);
        test_no_idle();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/swmm_pkg.sv
rtl/swmm_ram.sv
rtl/swmm_deque.sv
rtl/sliding_window_max_min.sv
rtl/swmm_checker.sv
tb/sliding_window_max_min_tb.sv
